>>> hw/rtl/wsd_pkg.sv
package wsd_pkg;

    // Header bit fields
    localparam logic [7:0] BIT_FIN   = 8'b1000_0000;
    localparam logic [7:0] BITS_RSV  = 8'b0111_0000;
    localparam logic [7:0] BITS_OPC  = 8'b0000_1111;
    localparam logic [7:0] BIT_MASK  = 8'b1000_0000;
    localparam logic [7:0] BITS_LEN  = 8'b0111_1111;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] OPC_CLOSE = 4'd8;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_FIN     = 3'd1,
        ERR_RSV     = 3'd2,
        ERR_UNMASK  = 3'd3,
        ERR_CLOSE   = 3'd4,
        ERR_LEN64   = 3'd5
    } err_t;

    // One result from the parser to the output register
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data_byte;
        logic [3:0] frame_opcode;
        logic       last;
        err_t       error_code;
    } wsd_result_t;

endpackage

>>> hw/rtl/wsd_parse.sv
module wsd_parse
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output wsd_result_t result
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT_HI,
        PH_EXT_LO,
        PH_MASK,
        PH_DATA,
        PH_DEAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] key_reg, key_next;
    logic [15:0] index_reg, index_next;

    logic [7:0]  key_byte;
    logic [16:0] index_inc;
    logic        is_last;

    assign key_byte  = key_reg[{index_reg[1:0], 3'b000} +: 8];
    assign index_inc = {1'b0, index_reg} + 17'd1;
    assign is_last   = (index_inc >= {1'b0, length_reg});

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        length_next = length_reg;
        key_next    = key_reg;
        index_next  = index_reg;

        result              = '0;
        result.kind         = KIND_DATA;
        result.error_code   = ERR_NONE;
        result.frame_opcode = opcode_reg;

        unique case (phase_reg)
            PH_HDR0:
            begin
                opcode_next         = rx_byte[3:0] & BITS_OPC[3:0];
                result.frame_opcode = opcode_next;
                priority if ((rx_byte & BIT_FIN) == 8'd0)
                begin
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_FIN;
                    phase_next        = PH_DEAD;
                end
                else if ((rx_byte & BITS_RSV) != 8'd0)
                begin
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_RSV;
                    phase_next        = PH_DEAD;
                end
                else
                begin
                    phase_next = PH_HDR1;
                end
            end
            PH_HDR1:
            begin
                priority if ((rx_byte & BIT_MASK) == 8'd0)
                begin
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_UNMASK;
                    phase_next        = PH_DEAD;
                end
                else if (opcode_reg == OPC_CLOSE)
                begin
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_CLOSE;
                    phase_next        = PH_DEAD;
                end
                else if (rx_byte[6:0] == LEN_EXT64)
                begin
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_LEN64;
                    phase_next        = PH_DEAD;
                end
                else
                begin
                    key_next   = '0;
                    index_next = '0;
                    if (rx_byte[6:0] == LEN_EXT16)
                    begin
                        length_next = '0;
                        phase_next  = PH_EXT_HI;
                    end
                    else
                    begin
                        length_next = {8'd0, rx_byte & BITS_LEN};
                        phase_next  = PH_MASK;
                    end
                end
            end
            PH_EXT_HI:
            begin
                length_next = {rx_byte, 8'd0};
                phase_next  = PH_EXT_LO;
            end
            PH_EXT_LO:
            begin
                length_next = {length_reg[15:8], rx_byte};
                phase_next  = PH_MASK;
            end
            PH_MASK:
            begin
                key_next[{index_reg[1:0], 3'b000} +: 8] = rx_byte;
                if (index_reg[1:0] == 2'd3)
                begin
                    index_next = '0;
                    if (length_reg == 16'd0)
                    begin
                        result.valid = 1'b1;
                        result.kind  = KIND_EMPTY;
                        result.last  = 1'b1;
                        phase_next   = PH_HDR0;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    index_next = index_inc[15:0];
                end
            end
            PH_DATA:
            begin
                result.valid     = 1'b1;
                result.kind      = KIND_DATA;
                result.data_byte = rx_byte ^ key_byte;
                result.last      = is_last;
                if (is_last)
                begin
                    index_next = '0;
                    phase_next = PH_HDR0;
                end
                else
                begin
                    index_next = index_inc[15:0];
                end
            end
            PH_DEAD:
            begin
                phase_next = PH_DEAD;
            end
            default:
            begin
                phase_next = PH_DEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            length_reg <= '0;
            key_reg    <= '0;
            index_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            length_reg <= length_next;
            key_reg    <= key_next;
            index_reg  <= index_next;
        end
    end

endmodule

>>> hw/rtl/websocket_frame_deframer.sv
// WebSocket client-to-server frame deframer with payload unmasking.
// Path: input register, then the parser, then the output register that drives the port.
// Throughput: one byte per cycle; in_ready drops only when the output register
//   holds a result that out_ready has not taken.
// Reset: rst_n asynchronous, active low; parser waits for a frame's first
//   header byte, input and output registers empty.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    // output channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic [3:0] frame_opcode,
    output logic       last,
    output logic [2:0] error_code
);

    // Input register: one byte waiting for the parser
    logic        in_valid_reg;
    logic [7:0]  byte_reg;

    // Output register: one finished result
    logic        out_valid_reg;
    wsd_result_t res_reg;

    wsd_result_t parse_res;
    logic        advance;

    // The held byte moves through the parser whenever the output register
    // can take whatever it produces (including nothing).
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    // Header state machine, mask key and unmasking
    wsd_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (byte_reg),
        .result  (parse_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= parse_res.valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && parse_res.valid)
        begin
            res_reg <= parse_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = res_reg.kind;
    assign data_byte    = res_reg.data_byte;
    assign frame_opcode = res_reg.frame_opcode;
    assign last         = res_reg.last;
    assign error_code   = res_reg.error_code;

    // An error result always carries a cause; other results never do.
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error_code does not match kind");

    // Empty-frame marker is flagged last and has no data.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_EMPTY) |-> (last && data_byte == 8'd0))
        else $error("malformed empty-frame result");

    // A stalled output register must hold the parser back.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !advance)
        else $error("parser advanced over a pending result");

    // After an error is delivered no further result appears.
    a_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && kind == KIND_ERROR) |=> !out_valid)
        else $error("result after connection error");

endmodule

>>> sim/wsd_deframe_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the deframer, predicts each request's result and
// checks every accepted result against the oldest prediction.
module wsd_deframe_checker
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    input  logic [3:0] frame_opcode,
    input  logic       last,
    input  logic [2:0] error_code,
    output int         pending,
    output int         fail_count
);

    typedef enum logic [2:0] {
        P_HDR0,
        P_HDR1,
        P_EXT_HI,
        P_EXT_LO,
        P_KEY,
        P_PAYLOAD,
        P_CLOSED
    } parse_phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [3:0] opc;
        logic       last;
        err_t       err;
    } deframe_result_t;

    parse_phase_t    st_phase;
    logic [3:0]      st_opcode;
    logic [15:0]     st_length;
    logic [31:0]     st_key;
    logic [15:0]     st_index;
    deframe_result_t expected_results[$];

    // Advances the parser by one byte; returns 1 when the byte yields a result.
    function automatic bit deframe_byte(input logic [7:0] b, output deframe_result_t r);
        logic [7:0] key_byte;
        logic       is_last;
        deframe_byte = 1'b0;
        r.kind = KIND_DATA;
        r.data = 8'h00;
        r.last = 1'b0;
        r.err  = ERR_NONE;
        case (st_phase)
            P_HDR0:
            begin
                st_opcode = b[3:0] & BITS_OPC[3:0];
                if ((b & BIT_FIN) == 8'h00)
                begin
                    r.kind = KIND_ERROR;
                    r.err  = ERR_FIN;
                end
                else if ((b & BITS_RSV) != 8'h00)
                begin
                    r.kind = KIND_ERROR;
                    r.err  = ERR_RSV;
                end
                else
                    st_phase = P_HDR1;
            end
            P_HDR1:
            begin
                if ((b & BIT_MASK) == 8'h00)
                begin
                    r.kind = KIND_ERROR;
                    r.err  = ERR_UNMASK;
                end
                else if (st_opcode == OPC_CLOSE)
                begin
                    r.kind = KIND_ERROR;
                    r.err  = ERR_CLOSE;
                end
                else if (b[6:0] == LEN_EXT64)
                begin
                    r.kind = KIND_ERROR;
                    r.err  = ERR_LEN64;
                end
                else
                begin
                    st_key   = 32'h0;
                    st_index = 16'h0;
                    if (b[6:0] == LEN_EXT16)
                    begin
                        st_length = 16'h0;
                        st_phase  = P_EXT_HI;
                    end
                    else
                    begin
                        st_length = {9'd0, b[6:0]};
                        st_phase  = P_KEY;
                    end
                end
            end
            P_EXT_HI:
            begin
                st_length = {b, 8'h00};
                st_phase  = P_EXT_LO;
            end
            P_EXT_LO:
            begin
                st_length = st_length | {8'h00, b};
                st_phase  = P_KEY;
            end
            P_KEY:
            begin
                st_key   = st_key | ({24'd0, b} << (8 * st_index[1:0]));
                st_index = st_index + 16'd1;
                if (st_index >= 16'd4)
                begin
                    st_index = 16'h0;
                    if (st_length == 16'h0)
                    begin
                        st_phase     = P_HDR0;
                        r.kind       = KIND_EMPTY;
                        r.last       = 1'b1;
                        deframe_byte = 1'b1;
                    end
                    else
                        st_phase = P_PAYLOAD;
                end
            end
            P_PAYLOAD:
            begin
                key_byte     = 8'(st_key >> (8 * st_index[1:0]));
                is_last      = ({16'd0, st_index} + 32'd1) >= {16'd0, st_length};
                r.data       = b ^ key_byte;
                r.last       = is_last;
                deframe_byte = 1'b1;
                st_index     = st_index + 16'd1;
                if (is_last)
                begin
                    st_phase = P_HDR0;
                    st_index = 16'h0;
                end
            end
            default: ;
        endcase
        if (r.kind == KIND_ERROR)
        begin
            st_phase     = P_CLOSED;
            deframe_byte = 1'b1;
        end
        r.opc = st_opcode;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deframe_result_t fresh;
        deframe_result_t want;
        bit              bad;
        if (!rst_n)
        begin
            st_phase   = P_HDR0;
            st_opcode  = 4'h0;
            st_length  = 16'h0;
            st_key     = 32'h0;
            st_index   = 16'h0;
            expected_results.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (deframe_byte(rx_byte, fresh))
                    expected_results.push_back(fresh);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d data %0h opcode %0d last %0d err %0d",
                           kind, data_byte, frame_opcode, last, error_code);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad  = 1'b0;
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        bad = 1'b1;
                    end
                    if (data_byte !== want.data)
                    begin
                        $error("data_byte: expected %0h, got %0h", want.data, data_byte);
                        bad = 1'b1;
                    end
                    if (frame_opcode !== want.opc)
                    begin
                        $error("frame_opcode: expected %0d, got %0d", want.opc, frame_opcode);
                        bad = 1'b1;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        bad = 1'b1;
                    end
                    if (error_code !== want.err)
                    begin
                        $error("error_code: expected %0d, got %0d", want.err, error_code);
                        bad = 1'b1;
                    end
                    if (bad)
                        fail_count <= fail_count + 1;
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

// Top of the deframer bench: clock, reset, byte stream, output backpressure
// and the verdict. All prediction and checking lives in the checker.
module tb_top
    import wsd_pkg::*;
();

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       last;
    logic [2:0] error_code;

    int pending;
    int fail_count;
    // requests accepted so far; the sink also keys its long hold off this
    int bytes_sent = 0;

    websocket_frame_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_opcode (frame_opcode),
        .last         (last),
        .error_code   (error_code)
    );

    wsd_deframe_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_opcode (frame_opcode),
        .last         (last),
        .error_code   (error_code),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length for either side: mostly none or a few cycles, now and then
    // a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            idle_cycles = 0;
        else if (r < 85)
            idle_cycles = $urandom_range(1, 3);
        else if (r < 97)
            idle_cycles = $urandom_range(4, 12);
        else
            idle_cycles = $urandom_range(20, 60);
    endfunction

    // Offers one request and returns at the edge that accepts it. Valid stays
    // high across back-to-back requests; it only drops when a gap is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // One well-formed client frame: header, optional 16-bit length, key,
    // then random masked payload.
    task automatic send_frame(input logic [3:0] opc, input int unsigned len,
                              input bit ext_form, input logic [31:0] key);
        logic [15:0] len16;
        len16 = 16'(len);
        send_byte(BIT_FIN | {4'h0, opc});
        if (ext_form)
        begin
            send_byte(BIT_MASK | {1'b0, LEN_EXT16});
            send_byte(len16[15:8]);
            send_byte(len16[7:0]);
        end
        else
            send_byte(BIT_MASK | {1'b0, len16[6:0]});
        for (int k = 0; k < 4; k++)
            send_byte(key[8*k +: 8]);
        for (int k = 0; k < len; k++)
            send_byte(8'($urandom));
    endtask

    // Drop valid and hold until every predicted result has come out. The
    // first edge lets the checker count the request accepted just before.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Any opcode but close, so the connection stays up.
    function automatic logic [3:0] open_opcode();
        logic [3:0] opc;
        opc = 4'($urandom_range(0, 15));
        while (opc == OPC_CLOSE)
            opc = 4'($urandom_range(0, 15));
        open_opcode = opc;
    endfunction

    // Output side: random ready bursts and gaps, plus one long hold once the
    // stream is well under way so the output register and the input stall.
    initial
    begin : result_sink
        int n;
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            n = $urandom_range(1, 40);
            repeat (n)
            begin
                @(posedge clk);
                out_ready <= 1'b1;
            end
            if (!held && bytes_sent >= 150)
            begin
                n    = 400;
                held = 1'b1;
            end
            else
                n = idle_cycles();
            repeat (n)
            begin
                @(posedge clk);
                out_ready <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int   r;
        bit   drained;
        err_t fault;
        drained = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty frame in the 7-bit form, empty frame in the 126 form
        // (mask key still consumed), then a short reserved-opcode frame whose
        // key and payload hit all-zero and all-one bytes.
        send_frame(4'd1, 0, 1'b0, 32'hA5C3_0F81);
        send_frame(4'd2, 0, 1'b1, 32'h1234_5678);
        send_byte(BIT_FIN | {4'h0, 4'hF});
        send_byte(BIT_MASK | 8'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);

        // Random frames, mostly short, some in the 16-bit length form, a few
        // at or near the 7-bit maximum or past 255 bytes.
        while (bytes_sent < 550)
        begin
            if (!drained && bytes_sent >= 300)
            begin
                wait_drained();
                drained = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 55)
                send_frame(open_opcode(), $urandom_range(0, 6), 1'b0, $urandom);
            else if (r < 75)
                send_frame(open_opcode(), $urandom_range(7, 40), 1'b0, $urandom);
            else if (r < 78)
                send_frame(open_opcode(), $urandom_range(120, 125), 1'b0, $urandom);
            else if (r < 95)
                send_frame(open_opcode(), $urandom_range(0, 20), 1'b1, $urandom);
            else
                send_frame(open_opcode(), $urandom_range(256, 280), 1'b1, $urandom);
        end

        // The connection can die only once per reset, so the run ends with a
        // single header fault picked at random, followed by bytes that the
        // closed parser must swallow.
        fault = err_t'($urandom_range(ERR_FIN, ERR_LEN64));
        case (fault)
            ERR_FIN:
                send_byte(8'($urandom) & ~BIT_FIN);
            ERR_RSV:
                send_byte({1'b1, 3'($urandom_range(1, 7)), 4'($urandom)});
            ERR_UNMASK:
            begin
                send_byte(BIT_FIN | {4'h0, 4'($urandom)});
                send_byte(8'($urandom) & BITS_LEN);
            end
            ERR_CLOSE:
            begin
                send_byte(BIT_FIN | {4'h0, OPC_CLOSE});
                send_byte(BIT_MASK | (8'($urandom) & BITS_LEN));
            end
            default:
            begin
                send_byte(BIT_FIN | {4'h0, open_opcode()});
                send_byte(BIT_MASK | {1'b0, LEN_EXT64});
            end
        endcase
        repeat (12)
            send_byte(8'($urandom));

        wait_drained();
        // input and output registers in the pipe: the extra edges catch any stray result
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hang guard, far past the slowest legal run.
    initial
    begin : watchdog
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_parse.sv
hw/rtl/websocket_frame_deframer.sv
sim/wsd_deframe_checker.sv
sim/tb_top.sv
